### rtl/rmf_pkg.sv
// Package of the reply message framer: parse phases, element kinds,
// error codes, control states and the byte constants of the wire format.
// No dependencies.
package rmf_pkg;

    localparam int MAX_DEPTH_DEF = 8;
    localparam int LEN_WIDTH_DEF = 32;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LINE    = 3'd1,
        PH_LINE_CR = 3'd2,
        PH_LEN     = 3'd3,
        PH_LEN_CR  = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_LINE = 2'd0,
        KIND_BULK = 2'd1,
        KIND_AGG  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_PREFIX   = 2'd1,
        ERR_DEPTH    = 2'd2,
        ERR_OVERFLOW = 2'd3
    } err_t;

    typedef enum logic [0:0] {
        ENG_RUN    = 1'b0,
        ENG_UNWIND = 1'b1
    } eng_state_t;

endpackage

### rtl/rmf_byte_if.sv
// Input channel of the framer: one stream byte per item.
// Depends on nothing.
interface rmf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

### rtl/rmf_result_if.sv
// Result channel of the framer: end flag, error code and top kind per item.
// Depends on nothing.
interface rmf_result_if;
    logic       valid;
    logic       ready;
    logic       message_end;
    logic [1:0] error_code;
    logic [1:0] top_kind;

    modport source (output valid, output message_end, output error_code,
                    output top_kind, input ready);
    modport sink (input valid, input message_end, input error_code,
                  input top_kind, output ready);
endinterface

### rtl/resp_message_framer.sv
// Top level of the reply message framer: parser, count stack memory and
// output register. Depends on rmf_pkg, rmf_byte_if and rmf_result_if.
//
//  channel  role    payload
//  -------  ------  ------------------------------------------
//  stream   sink    data_byte [7:0]
//  frame    source  message_end, error_code [1:0], top_kind [1:0]
//
// A byte that empties the count on top of the stack pops it, and each
// further level it unwinds needs one more read of the next count from the
// read port of the stack memory; no byte is accepted while these reads run.
// The top count is held in a register; the memory holds the levels below.
// A result waits in the output register until it is taken, and no byte is
// accepted while it waits unless it leaves in the same cycle.
// Reset clears all control state; the stack memory needs no clearing.
module resp_message_framer #(
    parameter int MAX_DEPTH = rmf_pkg::MAX_DEPTH_DEF,
    parameter int LEN_WIDTH = rmf_pkg::LEN_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rmf_byte_if.sink     stream,
    rmf_result_if.source frame
);
    import rmf_pkg::*;

    localparam int LVL_W  = $clog2(MAX_DEPTH + 1);
    localparam int ADDR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_W  = LEN_WIDTH + 1;
    localparam int PROD_W = LEN_WIDTH + 4;

    eng_state_t             eng_reg, eng_next;
    phase_t                 phase_reg, phase_next;
    kind_t                  kind_reg, kind_next;
    logic                   map_reg, map_next;
    logic [LEN_WIDTH-1:0]   accum_reg, accum_next;
    logic                   neg_reg, neg_next;
    logic [CNT_W-1:0]       remain_reg, remain_next;
    logic [CNT_W-1:0]       top_reg, top_next;
    logic [LVL_W-1:0]       level_reg, level_next;
    kind_t                  hold_reg, hold_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_end_reg, out_end_next;
    err_t                   out_err_reg, out_err_next;
    kind_t                  out_kind_reg, out_kind_next;

    logic [CNT_W-1:0]       stack_mem [MAX_DEPTH];
    logic [CNT_W-1:0]       rd_data_reg;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [CNT_W-1:0]       wr_data;

    logic                   accept;
    logic                   finish;
    logic                   res_end;
    err_t                   res_err;
    logic                   do_complete;
    logic                   do_len_char;
    logic [7:0]             b;
    logic [3:0]             digit;
    logic [PROD_W-1:0]      prod;
    logic                   ovf;
    logic [CNT_W-1:0]       cnt;
    logic [LVL_W-1:0]       lvl_m1;
    logic [LVL_W-1:0]       lvl_m2;

    assign accept = stream.valid && stream.ready;
    assign b      = stream.data_byte;
    assign digit  = 4'(b - CH_ZERO);
    assign prod   = PROD_W'({accum_reg, 3'b000}) + PROD_W'({accum_reg, 1'b0})
                    + PROD_W'(digit);
    assign ovf    = |prod[PROD_W-1:LEN_WIDTH];
    assign cnt    = map_reg ? {accum_reg, 1'b0} : {1'b0, accum_reg};
    assign lvl_m1 = level_reg - LVL_W'(1);
    assign lvl_m2 = level_reg - LVL_W'(2);

    always_comb
    begin
        eng_next = eng_reg;
        if (eng_reg == ENG_RUN)
        begin
            if (accept && rd_en)
            begin
                eng_next = ENG_UNWIND;
            end
        end
        else
        begin
            if (finish)
            begin
                eng_next = ENG_RUN;
            end
        end
    end

    always_comb
    begin
        stream.ready = (eng_reg == ENG_RUN) && (!out_valid_reg || frame.ready);
        frame.valid       = out_valid_reg;
        frame.message_end = out_end_reg;
        frame.error_code  = out_err_reg;
        frame.top_kind    = out_kind_reg;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        map_next    = map_reg;
        accum_next  = accum_reg;
        neg_next    = neg_reg;
        remain_next = remain_reg;
        top_next    = top_reg;
        level_next  = level_reg;
        hold_next   = hold_reg;
        finish      = 1'b0;
        res_end     = 1'b0;
        res_err     = ERR_NONE;
        do_complete = 1'b0;
        do_len_char = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = lvl_m2[ADDR_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = lvl_m1[ADDR_W-1:0];
        wr_data     = top_reg;

        if (eng_reg == ENG_RUN)
        begin
            if (accept)
            begin
                finish = 1'b1;
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if (b == CH_PLUS || b == CH_MINUS || b == CH_COLON ||
                            b == CH_UNDER || b == CH_HASH || b == CH_COMMA ||
                            b == CH_LPAREN)
                        begin
                            kind_next  = KIND_LINE;
                            phase_next = PH_LINE;
                        end
                        else if (b == CH_BANG || b == CH_EQUAL ||
                                 b == CH_DOLLAR)
                        begin
                            kind_next  = KIND_BULK;
                            phase_next = PH_LEN;
                        end
                        else if (b == CH_STAR || b == CH_PCT)
                        begin
                            kind_next  = KIND_AGG;
                            phase_next = PH_LEN;
                        end
                        else
                        begin
                            res_err = ERR_PREFIX;
                        end
                        map_next   = (b == CH_PCT);
                        accum_next = '0;
                        neg_next   = 1'b0;
                        if (level_reg == '0)
                        begin
                            hold_next = kind_next;
                        end
                    end
                    PH_LINE, PH_LINE_CR:
                    begin
                        if (b == CH_CR)
                        begin
                            phase_next = PH_LINE_CR;
                        end
                        else if (b == CH_LF && phase_reg == PH_LINE_CR)
                        begin
                            do_complete = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_LINE;
                        end
                    end
                    PH_LEN_CR:
                    begin
                        if (b == CH_LF)
                        begin
                            if (kind_reg == KIND_BULK)
                            begin
                                if (neg_reg)
                                begin
                                    do_complete = 1'b1;
                                end
                                else
                                begin
                                    remain_next = {1'b0, accum_reg} + CNT_W'(2);
                                    phase_next  = PH_PAYLOAD;
                                end
                            end
                            else if (neg_reg || cnt == '0)
                            begin
                                do_complete = 1'b1;
                            end
                            else if (level_reg >= LVL_W'(MAX_DEPTH))
                            begin
                                res_err = ERR_DEPTH;
                            end
                            else
                            begin
                                wr_en      = (level_reg != '0);
                                top_next   = cnt;
                                level_next = level_reg + LVL_W'(1);
                                phase_next = PH_IDLE;
                                accum_next = '0;
                                neg_next   = 1'b0;
                            end
                        end
                        else if (b != CH_CR)
                        begin
                            phase_next  = PH_LEN;
                            do_len_char = 1'b1;
                        end
                    end
                    PH_LEN:
                    begin
                        if (b == CH_CR)
                        begin
                            phase_next = PH_LEN_CR;
                        end
                        else
                        begin
                            do_len_char = 1'b1;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        if (remain_reg > CNT_W'(1))
                        begin
                            remain_next = remain_reg - CNT_W'(1);
                        end
                        else
                        begin
                            do_complete = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase

                if (do_len_char)
                begin
                    if (b == CH_MINUS)
                    begin
                        neg_next = 1'b1;
                    end
                    else if (b >= CH_ZERO && b <= CH_NINE)
                    begin
                        if (ovf)
                        begin
                            res_err = ERR_OVERFLOW;
                        end
                        else
                        begin
                            accum_next = prod[LEN_WIDTH-1:0];
                        end
                    end
                end

                if (do_complete)
                begin
                    phase_next  = PH_IDLE;
                    accum_next  = '0;
                    neg_next    = 1'b0;
                    remain_next = '0;
                    if (level_reg == '0)
                    begin
                        res_end = 1'b1;
                    end
                    else if (top_reg > CNT_W'(1))
                    begin
                        top_next = top_reg - CNT_W'(1);
                    end
                    else
                    begin
                        level_next = lvl_m1;
                        if (level_reg == LVL_W'(1))
                        begin
                            res_end = 1'b1;
                        end
                        else
                        begin
                            rd_en  = 1'b1;
                            finish = 1'b0;
                        end
                    end
                end
            end
        end
        else
        begin
            if (rd_data_reg > CNT_W'(1))
            begin
                top_next = rd_data_reg - CNT_W'(1);
                finish   = 1'b1;
            end
            else
            begin
                level_next = lvl_m1;
                if (level_reg == LVL_W'(1))
                begin
                    res_end = 1'b1;
                    finish  = 1'b1;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
        end

        if (res_err != ERR_NONE)
        begin
            phase_next  = PH_IDLE;
            kind_next   = KIND_LINE;
            map_next    = 1'b0;
            accum_next  = '0;
            neg_next    = 1'b0;
            remain_next = '0;
            level_next  = '0;
            hold_next   = KIND_LINE;
            wr_en       = 1'b0;
            res_end     = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !frame.ready;
        out_end_next   = out_end_reg;
        out_err_next   = out_err_reg;
        out_kind_next  = out_kind_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
            out_end_next   = res_end;
            out_err_next   = res_err;
            out_kind_next  = res_end ? hold_reg : KIND_LINE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_reg       <= ENG_RUN;
            phase_reg     <= PH_IDLE;
            kind_reg      <= KIND_LINE;
            map_reg       <= 1'b0;
            accum_reg     <= '0;
            neg_reg       <= 1'b0;
            remain_reg    <= '0;
            level_reg     <= '0;
            hold_reg      <= KIND_LINE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            eng_reg       <= eng_next;
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            map_reg       <= map_next;
            accum_reg     <= accum_next;
            neg_reg       <= neg_next;
            remain_reg    <= remain_next;
            level_reg     <= level_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        out_end_reg  <= out_end_next;
        out_err_reg  <= out_err_next;
        out_kind_reg <= out_kind_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_W'(MAX_DEPTH))
        else $error("stack level exceeds the stack depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (eng_reg == ENG_UNWIND) |-> (!out_valid_reg && level_reg != '0))
        else $error("unwinding with a pending result or an empty stack");

    assert property (@(posedge clk) disable iff (!rst_n)
        (finish && res_err != ERR_NONE) |=>
            (level_reg == '0 && phase_reg == PH_IDLE && frame.valid &&
             !frame.message_end && frame.top_kind == KIND_LINE))
        else $error("error result did not return the framer to idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en || rd_en) |-> (level_reg >= LVL_W'(1)))
        else $error("stack memory accessed with no level below the top");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench of resp_message_framer: directed and random reply byte streams with
// random idling on both channels, each item checked against a predictor or the table.
// Depends on rmf_pkg, rmf_byte_if, rmf_result_if and resp_message_framer.
module tb;
    import rmf_pkg::*;

    localparam int LEN_W = LEN_WIDTH_DEF;
    localparam int DEPTH = MAX_DEPTH_DEF;
    localparam longint unsigned LEN_MAX = (64'd1 << LEN_W) - 64'd1;
    localparam int RANDOM_ITEMS = 1300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [7:0] CH_ONE = CH_ZERO + 8'd1;

    typedef struct packed {
        logic  message_end;
        err_t  error_code;
        kind_t top_kind;
    } frame_t;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        frame_t     want;
    } stim_row_t;

    localparam frame_t QUIET = '{1'b0, ERR_NONE, KIND_LINE};

    stim_row_t directed_rows [26] = '{
        '{8'h00, 1'b1, '{1'b0, ERR_PREFIX, KIND_LINE}},
        '{8'hFF, 1'b1, '{1'b0, ERR_PREFIX, KIND_LINE}},
        '{CH_PLUS, 1'b0, QUIET},
        '{CH_CR, 1'b0, QUIET},
        '{CH_CR, 1'b0, QUIET},
        '{CH_LF, 1'b1, '{1'b1, ERR_NONE, KIND_LINE}},
        '{CH_DOLLAR, 1'b0, QUIET},
        '{CH_MINUS, 1'b0, QUIET},
        '{CH_ONE, 1'b0, QUIET},
        '{CH_CR, 1'b0, QUIET},
        '{CH_LF, 1'b1, '{1'b1, ERR_NONE, KIND_BULK}},
        '{CH_PCT, 1'b0, QUIET},
        '{CH_ZERO, 1'b0, QUIET},
        '{CH_CR, 1'b0, QUIET},
        '{CH_LF, 1'b1, '{1'b1, ERR_NONE, KIND_AGG}},
        '{CH_DOLLAR, 1'b0, QUIET},
        '{CH_NINE, 1'b0, QUIET},
        '{CH_NINE, 1'b0, QUIET},
        '{CH_NINE, 1'b0, QUIET},
        '{CH_NINE, 1'b0, QUIET},
        '{CH_NINE, 1'b0, QUIET},
        '{CH_NINE, 1'b0, QUIET},
        '{CH_NINE, 1'b0, QUIET},
        '{CH_NINE, 1'b0, QUIET},
        '{CH_NINE, 1'b0, QUIET},
        '{CH_NINE, 1'b1, '{1'b0, ERR_OVERFLOW, KIND_LINE}}
    };

    logic clk = 1'b0;
    logic rst_n;

    rmf_byte_if   byte_ch ();
    rmf_result_if frame_ch ();

    resp_message_framer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .stream(byte_ch),
        .frame (frame_ch)
    );

    always #2 clk = ~clk;

    // Predicted framer state.
    phase_t           rx_phase;
    kind_t            rx_kind;
    logic             rx_map;
    logic [LEN_W-1:0] rx_len;
    logic             rx_neg;
    logic [LEN_W:0]   rx_remain;
    logic [LEN_W:0]   rx_counts [DEPTH];
    int               rx_level;
    kind_t            rx_top;

    frame_t     expected_frames [$];
    logic [7:0] pending_bytes [$];
    frame_t     want_frame;
    int         failures = 0;
    int         sent_count = 0;
    bit         send_calm = 1'b0;
    int         sink_cycle = 0;
    bit         sink_calm = 1'b0;
    int         stall_left = 0;
    int         sink_pick;
    int         idle_cycles;
    int         random_items;

    function automatic void clear_framer_state();
        rx_phase = PH_IDLE;
        rx_kind = KIND_LINE;
        rx_map = 1'b0;
        rx_len = '0;
        rx_neg = 1'b0;
        rx_remain = '0;
        for (int i = 0; i < DEPTH; i++)
            rx_counts[i] = '0;
        rx_level = 0;
        rx_top = KIND_LINE;
    endfunction

    function automatic logic close_element();
        rx_phase = PH_IDLE;
        rx_len = '0;
        rx_neg = 1'b0;
        rx_remain = '0;
        while (rx_level > 0)
        begin
            if (rx_counts[rx_level-1] > 1)
            begin
                rx_counts[rx_level-1] = rx_counts[rx_level-1] - 1;
                return 1'b0;
            end
            rx_counts[rx_level-1] = '0;
            rx_level = rx_level - 1;
        end
        return 1'b1;
    endfunction

    function automatic frame_t frame_of_byte(logic [7:0] b);
        frame_t          r;
        err_t            err;
        logic            done;
        logic            as_len;
        longint unsigned cnt;
        longint unsigned digit;
        err = ERR_NONE;
        done = 1'b0;
        as_len = 1'b0;
        case (rx_phase)
            PH_IDLE:
            begin
                case (b)
                    CH_PLUS, CH_MINUS, CH_COLON, CH_UNDER, CH_HASH, CH_COMMA, CH_LPAREN:
                    begin
                        rx_kind = KIND_LINE;
                        rx_phase = PH_LINE;
                    end
                    CH_BANG, CH_EQUAL, CH_DOLLAR:
                    begin
                        rx_kind = KIND_BULK;
                        rx_phase = PH_LEN;
                    end
                    CH_STAR, CH_PCT:
                    begin
                        rx_kind = KIND_AGG;
                        rx_phase = PH_LEN;
                    end
                    default: err = ERR_PREFIX;
                endcase
                if (err == ERR_NONE)
                begin
                    rx_map = (b == CH_PCT);
                    rx_len = '0;
                    rx_neg = 1'b0;
                    if (rx_level == 0)
                        rx_top = rx_kind;
                end
            end
            PH_LINE, PH_LINE_CR:
            begin
                if (b == CH_CR)
                    rx_phase = PH_LINE_CR;
                else if (b == CH_LF && rx_phase == PH_LINE_CR)
                    done = close_element();
                else
                    rx_phase = PH_LINE;
            end
            PH_LEN_CR:
            begin
                if (b == CH_LF)
                begin
                    if (rx_kind == KIND_BULK)
                    begin
                        if (rx_neg)
                            done = close_element();
                        else
                        begin
                            rx_remain = {1'b0, rx_len} + 2;
                            rx_phase = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        cnt = rx_len;
                        if (rx_map)
                            cnt = cnt * 2;
                        if (rx_neg || cnt == 0)
                            done = close_element();
                        else if (rx_level >= DEPTH)
                            err = ERR_DEPTH;
                        else
                        begin
                            rx_counts[rx_level] = cnt[LEN_W:0];
                            rx_level = rx_level + 1;
                            rx_phase = PH_IDLE;
                            rx_len = '0;
                            rx_neg = 1'b0;
                        end
                    end
                end
                else if (b != CH_CR)
                begin
                    rx_phase = PH_LEN;
                    as_len = 1'b1;
                end
            end
            PH_LEN: as_len = 1'b1;
            PH_PAYLOAD:
            begin
                if (rx_remain > 1)
                    rx_remain = rx_remain - 1;
                else
                    done = close_element();
            end
            default: rx_phase = PH_IDLE;
        endcase
        if (as_len)
        begin
            if (b == CH_CR)
                rx_phase = PH_LEN_CR;
            else if (b == CH_MINUS)
                rx_neg = 1'b1;
            else if (b >= CH_ZERO && b <= CH_NINE)
            begin
                digit = b - CH_ZERO;
                if (rx_len > (LEN_MAX - digit) / 10)
                    err = ERR_OVERFLOW;
                else
                    rx_len = rx_len * 10 + digit;
            end
        end
        if (err != ERR_NONE)
        begin
            clear_framer_state();
            done = 1'b0;
        end
        r.message_end = done;
        r.error_code = err;
        r.top_kind = done ? rx_top : KIND_LINE;
        return r;
    endfunction

    function automatic void put_number(longint unsigned v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
            pending_bytes.push_back(s[i]);
    endfunction

    function automatic void put_header(logic [7:0] prefix, longint unsigned n, bit nul);
        bit minus_first;
        minus_first = $urandom_range(0, 1);
        pending_bytes.push_back(prefix);
        if ($urandom_range(0, 19) == 0)
            pending_bytes.push_back(8'h61 + 8'($urandom_range(0, 25)));
        if ($urandom_range(0, 24) == 0)
            pending_bytes.push_back(CH_CR);
        if (nul && minus_first)
            pending_bytes.push_back(CH_MINUS);
        put_number(n);
        if (nul && !minus_first)
            pending_bytes.push_back(CH_MINUS);
        if ($urandom_range(0, 24) == 0)
            pending_bytes.push_back(CH_CR);
        pending_bytes.push_back(CH_CR);
        pending_bytes.push_back(CH_LF);
    endfunction

    function automatic logic [7:0] pick_line_prefix();
        case ($urandom_range(0, 6))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_COLON;
            3: return CH_UNDER;
            4: return CH_HASH;
            5: return CH_COMMA;
            default: return CH_LPAREN;
        endcase
    endfunction

    function automatic logic [7:0] pick_bulk_prefix();
        case ($urandom_range(0, 2))
            0: return CH_BANG;
            1: return CH_EQUAL;
            default: return CH_DOLLAR;
        endcase
    endfunction

    function automatic void put_line();
        int         body_len;
        logic [7:0] c;
        body_len = $urandom_range(0, 6);
        pending_bytes.push_back(pick_line_prefix());
        for (int i = 0; i < body_len; i++)
        begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_CR || c == CH_LF)
                c = 8'h20;
            pending_bytes.push_back(c);
        end
        if ($urandom_range(0, 19) == 0)
        begin
            pending_bytes.push_back(CH_CR);
            pending_bytes.push_back(8'h41);
        end
        pending_bytes.push_back(CH_CR);
        pending_bytes.push_back(CH_LF);
    endfunction

    function automatic void put_bulk();
        int len;
        if ($urandom_range(0, 15) == 0)
        begin
            put_header(pick_bulk_prefix(), 1, 1'b1);
            return;
        end
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        put_header(pick_bulk_prefix(), len, 1'b0);
        for (int i = 0; i < len; i++)
            pending_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0)
        begin
            pending_bytes.push_back(8'($urandom_range(0, 255)));
            pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            pending_bytes.push_back(CH_CR);
            pending_bytes.push_back(CH_LF);
        end
    endfunction

    function automatic void put_message();
        int open_counts [$];
        int nest_cap;
        int n;
        int cnt;
        int r;
        bit nul;
        bit is_map;
        bit settled;
        nest_cap = $urandom_range(0, 3);
        do
        begin
            settled = 1'b0;
            r = $urandom_range(0, 99);
            if (open_counts.size() < nest_cap && r < 35)
            begin
                is_map = $urandom_range(0, 1);
                n = $urandom_range(0, is_map ? 2 : 3);
                nul = ($urandom_range(0, 19) == 0);
                put_header(is_map ? CH_PCT : CH_STAR, n, nul);
                cnt = is_map ? 2 * n : n;
                if (!nul && cnt > 0)
                begin
                    open_counts.push_back(cnt);
                    settled = 1'b1;
                end
            end
            else if (r < 70)
                put_line();
            else
                put_bulk();
            while (!settled && open_counts.size() > 0)
            begin
                open_counts[open_counts.size()-1] -= 1;
                if (open_counts[open_counts.size()-1] > 0)
                    settled = 1'b1;
                else
                    void'(open_counts.pop_back());
            end
        end
        while (open_counts.size() > 0);
    endfunction

    function automatic void put_deep_chain();
        int levels;
        levels = $urandom_range(DEPTH - 2, DEPTH + 2);
        for (int i = 0; i < levels; i++)
        begin
            pending_bytes.push_back(CH_STAR);
            pending_bytes.push_back(CH_ONE);
            pending_bytes.push_back(CH_CR);
            pending_bytes.push_back(CH_LF);
        end
        put_line();
    endfunction

    function automatic void put_overflow();
        int extra;
        pending_bytes.push_back($urandom_range(0, 1) ? pick_bulk_prefix()
                                                   : ($urandom_range(0, 1) ? CH_STAR : CH_PCT));
        if ($urandom_range(0, 2) == 0)
            put_number(LEN_MAX + 1);
        else
        begin
            extra = $urandom_range(10, 12);
            pending_bytes.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
            for (int i = 0; i < extra; i++)
                pending_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    function automatic void put_largest_count();
        pending_bytes.push_back($urandom_range(0, 1) ? CH_STAR : CH_PCT);
        put_number(LEN_MAX);
        pending_bytes.push_back(CH_CR);
        pending_bytes.push_back(CH_LF);
        put_line();
        put_bulk();
        pending_bytes.push_back(8'h00);
    endfunction

    function automatic void build_chunk();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 72)
            put_message();
        else if (r < 80)
        begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 86)
            put_deep_chain();
        else if (r < 91)
            put_overflow();
        else if (r < 96 && rx_phase == PH_IDLE && rx_level == 0)
            put_largest_count();
        else
            put_message();
    endfunction

    function automatic int pick_gap();
        int r;
        sent_count++;
        if (sent_count % 150 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
        if (send_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic typed, input frame_t typed_frame);
        int     gap;
        frame_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        do @(posedge clk);
        while (!byte_ch.ready);
        predicted = frame_of_byte(b);
        expected_frames.push_back(typed ? typed_frame : predicted);
    endtask

    always @(posedge clk)
    begin
        if (sink_cycle % 200 == 0)
            sink_calm = ($urandom_range(0, 3) == 0);
        sink_cycle++;
        if (sink_calm)
            frame_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            frame_ch.ready <= 1'b0;
        end
        else
        begin
            sink_pick = $urandom_range(0, 99);
            if (sink_pick < 70)
                frame_ch.ready <= 1'b1;
            else
            begin
                frame_ch.ready <= 1'b0;
                stall_left = (sink_pick < 95) ? $urandom_range(0, 2) : $urandom_range(4, 19);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && frame_ch.valid && frame_ch.ready)
        begin
            if (expected_frames.size() == 0)
            begin
                $error("frame item arrived with nothing expected");
                failures++;
            end
            else
            begin
                want_frame = expected_frames.pop_front();
                if (frame_ch.message_end !== want_frame.message_end)
                begin
                    $error("message_end: expected %0d, got %0d",
                           want_frame.message_end, frame_ch.message_end);
                    failures++;
                end
                if (frame_ch.error_code !== want_frame.error_code)
                begin
                    $error("error_code: expected %0d, got %0d",
                           want_frame.error_code, frame_ch.error_code);
                    failures++;
                end
                if (frame_ch.top_kind !== want_frame.top_kind)
                begin
                    $error("top_kind: expected %0d, got %0d",
                           want_frame.top_kind, frame_ch.top_kind);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        do
        begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (frame_ch.valid && frame_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        while (idle_cycles < WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = 8'h00;
        frame_ch.ready = 1'b0;
        clear_framer_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            build_chunk();
            while (pending_bytes.size() > 0)
            begin
                send_byte(pending_bytes.pop_front(), 1'b0, QUIET);
                random_items++;
            end
        end
        byte_ch.valid <= 1'b0;

        while (expected_frames.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### resp_message_framer.f
rtl/rmf_pkg.sv
rtl/rmf_byte_if.sv
rtl/rmf_result_if.sv
rtl/resp_message_framer.sv
verif/tb.sv
